// ===== rtl/thermocouple_spike_rejecter_defines.svh =====
// Assertion macros shared by the spike rejecter RTL.
`ifndef THERMOCOUPLE_SPIKE_REJECTER_DEFINES_SVH
`define THERMOCOUPLE_SPIKE_REJECTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TSR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tsr assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TSR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tsr assertion failed");

`endif

// ===== rtl/tsr_pkg.sv =====
package tsr_pkg;

	localparam int unsigned RAW_W    = 16;
	localparam int unsigned TEMP_W   = 12;
	localparam int unsigned TRAW_W   = 13;
	localparam int unsigned COUNT_W  = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 12;
	localparam int unsigned OUT_DATA_W = 16;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OPEN   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOCOMM = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VALID_MIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VALID_MAX   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPIKE_LIMIT = 2'd3;

	// Register reset values
	localparam logic [TEMP_W-1:0]  VALID_MIN_RST   = 12'd0;
	localparam logic [TEMP_W-1:0]  VALID_MAX_RST   = 12'd4095;
	localparam logic [TEMP_W-1:0]  JUMP_LIMIT_RST  = 12'd80;
	localparam logic [COUNT_W-1:0] SPIKE_LIMIT_RST = 8'd3;

	localparam logic [RAW_W-1:0]   RAW_ALL_ONES = 16'hFFFF;
	localparam int unsigned        OPEN_BIT     = 2;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'd255;

endpackage

// ===== rtl/thermocouple_spike_rejecter.sv =====
// Thermocouple spike rejecter: takes one 16-bit converter word per beat (temperature in
// bits 15:3, quarter degrees, open-input flag in bit 2) with a link-failure flag in tuser,
// and returns one result beat: status, reading_ok and the reported temperature, which
// holds its previous value on faults. One beat is accepted every clock cycle while the
// result stream is not stalled; each result passes through the input register and then the
// result register around the single compare-and-count stage. Registers are written through the
// cfg channel, which is always ready; write them only while no beat is in flight.
`include "thermocouple_spike_rejecter_defines.svh"

module thermocouple_spike_rejecter (
	input  logic                           clk,
	input  logic                           arst_n,
	// cfg write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tsr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsr_pkg::CFG_DATA_W-1:0] cfg_data,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tsr_pkg::RAW_W-1:0]      s_tdata,   // [15:0] raw_word
	input  logic                           s_tuser,   // [0] link_fail
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tsr_pkg::OUT_DATA_W-1:0] m_tdata    // [1:0] status, [2] reading_ok,
	                                                  // [14:3] temperature, [15] zero
);
	import tsr_pkg::*;

	// Configuration registers
	logic [TEMP_W-1:0]  valid_min_q, valid_max_q, jump_limit_q;
	logic [COUNT_W-1:0] spike_limit_q;

	// Block state
	logic [TEMP_W-1:0]  last_good_q, shown_temp_q;
	logic               have_good_q;
	logic [COUNT_W-1:0] spike_count_q;

	// Input register
	logic               valid_s1;
	logic [RAW_W-1:0]   raw_s1;
	logic               fail_s1;

	// Result register
	logic                valid_s2;
	logic [STATUS_W-1:0] status_s2;
	logic                ok_s2;
	logic [TEMP_W-1:0]   temp_s2;

	logic advance;

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_min_q   <= VALID_MIN_RST;
			valid_max_q   <= VALID_MAX_RST;
			jump_limit_q  <= JUMP_LIMIT_RST;
			spike_limit_q <= SPIKE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_VALID_MIN:   valid_min_q   <= cfg_data;
				REG_VALID_MAX:   valid_max_q   <= cfg_data;
				REG_JUMP_LIMIT:  jump_limit_q  <= cfg_data;
				REG_SPIKE_LIMIT: spike_limit_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: s1 moves on when the result register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			raw_s1  <= s_tdata;
			fail_s1 <= s_tuser;
		end
	end

	// Classification and spike test
	logic [TRAW_W-1:0]   t_raw;
	logic [TRAW_W-1:0]   jump;
	logic                nocomm, open_in, out_range, spike;
	logic [COUNT_W-1:0]  count_inc;
	logic [STATUS_W-1:0] status_n;
	logic                take_good, count_upd;

	assign t_raw     = raw_s1[RAW_W-1:3];
	assign nocomm    = fail_s1 || (raw_s1 == RAW_ALL_ONES);
	assign open_in   = raw_s1[OPEN_BIT];
	assign out_range = (t_raw < {1'b0, valid_min_q}) || (t_raw > {1'b0, valid_max_q});
	assign jump      = (t_raw >= {1'b0, last_good_q}) ? (t_raw - {1'b0, last_good_q})
	                                                  : ({1'b0, last_good_q} - t_raw);
	assign spike     = have_good_q && (jump > {1'b0, jump_limit_q});
	assign count_inc = (spike_count_q == COUNT_MAX) ? spike_count_q
	                                                : spike_count_q + 1'b1;

	always_comb begin
		status_n  = ST_OK;
		take_good = 1'b0;
		count_upd = 1'b0;
		if (nocomm) begin
			status_n = ST_NOCOMM;
		end else if (open_in) begin
			status_n = ST_OPEN;
		end else if (out_range) begin
			status_n = ST_NOCOMM;
		end else if (spike) begin
			count_upd = 1'b1;
			status_n  = (count_inc < spike_limit_q) ? ST_OK : ST_NOCOMM;
		end else begin
			take_good = 1'b1;
		end
	end

	// State update as the beat passes into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_good_q   <= '0;
			have_good_q   <= 1'b0;
			spike_count_q <= '0;
			shown_temp_q  <= '0;
		end else if (advance) begin
			if (take_good) begin
				last_good_q   <= t_raw[TEMP_W-1:0];
				have_good_q   <= 1'b1;
				spike_count_q <= '0;
				shown_temp_q  <= t_raw[TEMP_W-1:0];
			end else if (count_upd) begin
				spike_count_q <= count_inc;
				if (status_n == ST_OK) begin
					shown_temp_q <= last_good_q;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= status_n;
			ok_s2     <= (status_n == ST_OK);
			if (take_good) begin
				temp_s2 <= t_raw[TEMP_W-1:0];
			end else if (count_upd && (status_n == ST_OK)) begin
				temp_s2 <= last_good_q;
			end else begin
				temp_s2 <= shown_temp_q;
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, temp_s2, ok_s2, status_s2};

	// Checks
	`TSR_ASSERT_NOW(a_ok_matches_status, m_tvalid, m_tdata[2] == (m_tdata[1:0] == ST_OK))
	`TSR_ASSERT_NOW(a_no_status_three, m_tvalid, m_tdata[1:0] != 2'd3)
	`TSR_ASSERT_NOW(a_no_count_without_good, !have_good_q, spike_count_q == '0)
	`TSR_ASSERT_NEXT(a_stall_keeps_s1, valid_s1 && valid_s2 && !m_tready,
		valid_s1 && $stable(raw_s1) && $stable(fail_s1))

endmodule
